FILE: design/glzw_pkg.sv
// ----------------------------------------------------------------------------
// glzw_pkg: shared types and codes for the GIF LZW code decoder
// Request and response beats, kind, status and mode codes.
// ----------------------------------------------------------------------------
`default_nettype none
package glzw_pkg;
   localparam logic [1:0] KIND_START = 2'd0;
   localparam logic [1:0] KIND_PUSH  = 2'd1;
   localparam logic [1:0] KIND_PULL  = 2'd2;

   localparam logic [2:0] ST_PIXEL   = 3'd0;
   localparam logic [2:0] ST_BYTE    = 3'd1;
   localparam logic [2:0] ST_NEED    = 3'd2;
   localparam logic [2:0] ST_FULL    = 3'd3;
   localparam logic [2:0] ST_END     = 3'd4;
   localparam logic [2:0] ST_ERROR   = 3'd5;
   localparam logic [2:0] ST_STARTED = 3'd6;

   localparam logic [1:0] MODE_FIRST  = 2'd0;
   localparam logic [1:0] MODE_NORMAL = 2'd1;
   localparam logic [1:0] MODE_ENDED  = 2'd2;
   localparam logic [1:0] MODE_ERROR  = 2'd3;

   typedef struct packed {
      logic [1:0] kind;
      logic [7:0] data_byte;
   } req_type;

   typedef struct packed {
      logic [7:0] pixel;
      logic [2:0] status;
   } rsp_type;
endpackage
`default_nettype wire

FILE: design/gif_lzw_code_decoder_top.sv
// ----------------------------------------------------------------------------
// gif_lzw_code_decoder_top: GIF LZW code stream decoder
// Sequencer around one table port, one stack port and a shared compare.
// ----------------------------------------------------------------------------
// Usage: raise start with a req beat while busy is low. kind start resets the
// stream, push appends a byte to the 40-bit LSB-first bit buffer, pull returns
// one pixel. Each accepted beat gives exactly one rsp beat, flagged by
// rsp_valid for one cycle; the receiver cannot stall, so nothing is held.
// busy rises the cycle after acceptance and is low again in the rsp cycle,
// so the next req beat can be taken while the rsp beat is out.
// Path through the states after acceptance: push, and a pull that ends or
// errors without reading a code, pass S_DECODE and S_DONE; a pull that
// reads a code but needs more bits, or takes the first literal, adds S_CODE;
// a pull served from the stack passes S_POP and S_POPRD; a pull that walks a
// chain of table entries visits a lookup state (S_WALK) and a registered read
// state (S_WALKRD) per entry, then S_TAIL, S_POP and S_POPRD before S_DONE.
// A start clears the entry valid bits with a sweep over all TABLE_ENTRIES
// entries; a clear code adds the same sweep to its pull. Reset runs the sweep
// before the first beat is taken (busy high meanwhile). Configuration writes
// are taken whenever csr_ready is high, which is whenever the block is idle.
// Kind 3 gives no rsp beat, holds busy for one cycle and changes nothing.
// ----------------------------------------------------------------------------
`default_nettype none
module gif_lzw_code_decoder_top #(
   parameter int TABLE_ENTRIES = 4096,
   parameter int MAX_CODE_BITS = 12
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             start,
   output logic                  busy,
   input  wire glzw_pkg::req_type req_data,
   output logic                  rsp_valid,
   output glzw_pkg::rsp_type     rsp_data,
   input  wire logic             csr_valid,
   output logic                  csr_ready,
   input  wire logic [3:0]       csr_data
);
   localparam int AW = $clog2(TABLE_ENTRIES);
   localparam int SW = $clog2(TABLE_ENTRIES + 2);
   localparam logic [SW-1:0] STACK_DEPTH = SW'(TABLE_ENTRIES + 1);
   localparam logic [12:0] TABLE_TOP = 13'(TABLE_ENTRIES);
   localparam logic [3:0] MAX_BITS = 4'(MAX_CODE_BITS);

   typedef enum logic [3:0] {
      S_SWEEP, S_IDLE, S_DECODE, S_CODE, S_WALK, S_WALKRD, S_TAIL, S_POP,
      S_POPRD, S_DONE
   } state_type;

   logic [11:0]   prefix_mem [TABLE_ENTRIES];
   logic [7:0]    suffix_mem [TABLE_ENTRIES];
   logic [7:0]    stack_mem  [TABLE_ENTRIES + 1];
   logic          valid_mem  [TABLE_ENTRIES];

   state_type     state_ff;
   logic [3:0]    min_ff;
   logic [1:0]    kind_ff;
   logic [7:0]    byte_ff;
   logic [SW-1:0] sp_ff;
   logic [39:0]   buf_ff;
   logic [5:0]    cnt_ff;
   logic [12:0]   nfc_ff;
   logic [3:0]    cw_ff;
   logic [12:0]   lim_ff;
   logic [11:0]   prev_ff;
   logic [7:0]    first_ff;
   logic [1:0]    mode_ff;
   logic [11:0]   code_ff;
   logic [12:0]   walk_ff;
   logic [AW-1:0] sweep_ff;
   logic [11:0]   rd_pre_ff;
   logic [7:0]    rd_suf_ff;
   logic          rd_val_ff;
   logic [7:0]    pop_ff;
   logic          sweep_all_ff;
   logic          started_ff;
   logic          rsp_valid_ff;
   glzw_pkg::rsp_type rsp_ff;

   logic [3:0]  emin;
   logic [12:0] clr;
   always_comb begin
      emin = min_ff;
      if (min_ff < 4'd2) emin = 4'd2;
      if (min_ff > 4'd8) emin = 4'd8;
      clr = 13'd1 << emin;
   end

   // stack write port, table write port
   logic          st_we;
   logic [SW-1:0] st_wa;
   logic [7:0]    st_wd;
   logic          tb_we;
   logic          tb_clr;

   logic [12:0] code13;
   logic [11:0] mask12;
   assign mask12 = 12'((13'd1 << cw_ff) - 13'd1);
   assign code13 = {1'b0, buf_ff[11:0] & mask12};

   logic [AW-1:0] walk_idx;
   assign walk_idx = walk_ff[AW-1:0];

   always_ff @(posedge clock) begin
      if (st_we) stack_mem[st_wa[SW-1:0]] <= st_wd;
      if (tb_we) begin
         prefix_mem[nfc_ff[AW-1:0]] <= prev_ff;
         suffix_mem[nfc_ff[AW-1:0]] <= walk_ff[7:0];
      end
      rd_pre_ff <= prefix_mem[walk_idx];
      rd_suf_ff <= suffix_mem[walk_idx];
      pop_ff    <= stack_mem[sp_ff];
   end

   always_ff @(posedge clock) begin
      if (tb_clr) valid_mem[sweep_ff] <= 1'b0;
      else if (tb_we) valid_mem[nfc_ff[AW-1:0]] <= 1'b1;
      rd_val_ff <= valid_mem[walk_idx];
   end

   always_comb begin
      st_we = 1'b0;
      st_wa = sp_ff;
      st_wd = 8'd0;
      tb_we = 1'b0;
      tb_clr = (state_ff == S_SWEEP);
      unique case (state_ff)
         S_CODE: begin
            if (mode_ff == glzw_pkg::MODE_NORMAL && code13 != clr
                  && code13 != clr + 13'd1 && code13 >= nfc_ff) begin
               st_we = 1'b1;
               st_wd = first_ff;
            end
         end
         S_WALKRD: begin
            st_we = 1'b1;
            st_wd = (walk_ff < TABLE_TOP && rd_val_ff) ? rd_suf_ff : 8'd0;
         end
         S_TAIL: begin
            st_we = 1'b1;
            st_wd = walk_ff[7:0];
            tb_we = (nfc_ff < TABLE_TOP) && (sp_ff < STACK_DEPTH);
         end
         default: ;
      endcase
      if (sp_ff >= STACK_DEPTH) st_we = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_SWEEP;
         min_ff <= 4'd8;
         sweep_ff <= '0;
         sweep_all_ff <= 1'b1;
         sp_ff <= '0;
         buf_ff <= '0;
         cnt_ff <= '0;
         nfc_ff <= 13'd258;
         cw_ff <= 4'd9;
         lim_ff <= 13'd512;
         prev_ff <= '0;
         first_ff <= '0;
         mode_ff <= glzw_pkg::MODE_FIRST;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= (state_ff == S_DONE);
         if (csr_valid && csr_ready) min_ff <= csr_data;
         unique case (state_ff)
            S_SWEEP: begin
               if (sweep_ff == AW'(TABLE_ENTRIES - 1)) begin
                  sweep_ff <= '0;
                  if (sweep_all_ff) begin
                     rsp_ff <= '{pixel: 8'd0, status: glzw_pkg::ST_STARTED};
                     state_ff <= started_ff ? S_DONE : S_IDLE;
                  end else begin
                     state_ff <= S_CODE;
                  end
               end else begin
                  sweep_ff <= sweep_ff + AW'(1);
               end
            end
            S_IDLE: begin
               if (start) begin
                  kind_ff <= req_data.kind;
                  byte_ff <= req_data.data_byte;
                  state_ff <= S_DECODE;
               end
            end
            S_DECODE: begin
               unique case (kind_ff)
                  glzw_pkg::KIND_START: begin
                     nfc_ff <= clr + 13'd2;
                     cw_ff <= emin + 4'd1;
                     lim_ff <= clr << 1;
                     sp_ff <= '0;
                     buf_ff <= '0;
                     cnt_ff <= '0;
                     prev_ff <= '0;
                     first_ff <= '0;
                     mode_ff <= glzw_pkg::MODE_FIRST;
                     sweep_all_ff <= 1'b1;
                     state_ff <= S_SWEEP;
                  end
                  glzw_pkg::KIND_PUSH: begin
                     if (cnt_ff > 6'd32) begin
                        rsp_ff <= '{pixel: 8'd0, status: glzw_pkg::ST_FULL};
                     end else begin
                        buf_ff <= buf_ff | (40'(byte_ff) << cnt_ff);
                        cnt_ff <= cnt_ff + 6'd8;
                        rsp_ff <= '{pixel: 8'd0, status: glzw_pkg::ST_BYTE};
                     end
                     state_ff <= S_DONE;
                  end
                  glzw_pkg::KIND_PULL: begin
                     if (sp_ff != '0) begin
                        sp_ff <= sp_ff - SW'(1);
                        state_ff <= S_POP;
                     end else if (mode_ff == glzw_pkg::MODE_ENDED) begin
                        rsp_ff <= '{pixel: 8'd0, status: glzw_pkg::ST_END};
                        state_ff <= S_DONE;
                     end else if (mode_ff == glzw_pkg::MODE_ERROR) begin
                        rsp_ff <= '{pixel: 8'd0, status: glzw_pkg::ST_ERROR};
                        state_ff <= S_DONE;
                     end else begin
                        state_ff <= S_CODE;
                     end
                  end
                  default: state_ff <= S_IDLE;
               endcase
            end
            S_CODE: begin
               if (cnt_ff < 6'(cw_ff)) begin
                  rsp_ff <= '{pixel: 8'd0, status: glzw_pkg::ST_NEED};
                  state_ff <= S_DONE;
               end else begin
                  buf_ff <= buf_ff >> cw_ff;
                  cnt_ff <= cnt_ff - 6'(cw_ff);
                  code_ff <= code13[11:0];
                  if (code13 == clr) begin
                     // clear: reset dictionary, then read the next code
                     nfc_ff <= clr + 13'd2;
                     cw_ff <= emin + 4'd1;
                     lim_ff <= clr << 1;
                     sp_ff <= '0;
                     mode_ff <= glzw_pkg::MODE_FIRST;
                     sweep_all_ff <= 1'b0;
                     state_ff <= S_SWEEP;
                  end else if (code13 == clr + 13'd1) begin
                     mode_ff <= glzw_pkg::MODE_ENDED;
                     rsp_ff <= '{pixel: 8'd0, status: glzw_pkg::ST_END};
                     state_ff <= S_DONE;
                  end else if (mode_ff == glzw_pkg::MODE_FIRST) begin
                     if (code13 > clr) begin
                        mode_ff <= glzw_pkg::MODE_ERROR;
                        rsp_ff <= '{pixel: 8'd0, status: glzw_pkg::ST_ERROR};
                     end else begin
                        prev_ff <= code13[11:0];
                        first_ff <= code13[7:0];
                        mode_ff <= glzw_pkg::MODE_NORMAL;
                        rsp_ff <= '{pixel: code13[7:0], status: glzw_pkg::ST_PIXEL};
                     end
                     state_ff <= S_DONE;
                  end else if (code13 >= nfc_ff) begin
                     // KwKwK: first symbol goes under the chain of previous
                     sp_ff <= sp_ff + SW'(1);
                     walk_ff <= {1'b0, prev_ff};
                     state_ff <= S_WALK;
                  end else begin
                     walk_ff <= code13;
                     state_ff <= S_WALK;
                  end
               end
            end
            S_WALK: begin
               if (walk_ff >= clr) begin
                  state_ff <= S_WALKRD;
               end else begin
                  state_ff <= S_TAIL;
               end
            end
            S_WALKRD: begin
               // one table entry per visit; drop on overflow or self loop
               if (sp_ff >= STACK_DEPTH || (walk_ff < TABLE_TOP && rd_val_ff
                     && 13'(rd_pre_ff) == walk_ff)) begin
                  mode_ff <= glzw_pkg::MODE_ERROR;
                  sp_ff <= '0;
                  rsp_ff <= '{pixel: 8'd0, status: glzw_pkg::ST_ERROR};
                  state_ff <= S_DONE;
               end else begin
                  sp_ff <= sp_ff + SW'(1);
                  if (walk_ff < TABLE_TOP && rd_val_ff) walk_ff <= 13'(rd_pre_ff);
                  else walk_ff <= 13'd0;
                  state_ff <= S_WALK;
               end
            end
            S_TAIL: begin
               // the tail pushes at sp then pops the same slot: sp is left unchanged
               if (sp_ff >= STACK_DEPTH) begin
                  mode_ff <= glzw_pkg::MODE_ERROR;
                  sp_ff <= '0;
                  rsp_ff <= '{pixel: 8'd0, status: glzw_pkg::ST_ERROR};
                  state_ff <= S_DONE;
               end else begin
                  first_ff <= walk_ff[7:0];
                  if (nfc_ff < TABLE_TOP) begin
                     nfc_ff <= nfc_ff + 13'd1;
                     if (nfc_ff + 13'd1 >= lim_ff && cw_ff < MAX_BITS) begin
                        lim_ff <= lim_ff << 1;
                        cw_ff <= cw_ff + 4'd1;
                     end
                  end
                  prev_ff <= code_ff;
                  state_ff <= S_POP;
               end
            end
            S_POP: state_ff <= S_POPRD;
            S_POPRD: begin
               rsp_ff <= '{pixel: pop_ff, status: glzw_pkg::ST_PIXEL};
               state_ff <= S_DONE;
            end
            S_DONE: begin
               state_ff <= S_IDLE;
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) started_ff <= 1'b0;
      else if (state_ff == S_DECODE) started_ff <= 1'b1;
   end

   always_comb begin
      busy = (state_ff != S_IDLE);
      csr_ready = (state_ff == S_IDLE);
      rsp_valid = rsp_valid_ff;
      rsp_data = rsp_ff;
   end

   a_one_rsp: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(state_ff) == S_DONE) else $error("stray rsp beat");
   a_idle_after_rsp: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !busy) else $error("busy with rsp");
   a_stack_bound: assert property (@(posedge clock) disable iff (reset)
      sp_ff <= STACK_DEPTH) else $error("stack pointer overrun");
endmodule
`default_nettype wire
